/* src/jctg_pkg.sv */
// shared types, codes and constants of the joint cosine trajectory generator
package jctg_pkg;

	localparam int NUM_JOINTS_DEF = 16;
	localparam int SINE_DEPTH_DEF = 1024;

	// iterative divider: numerator width, one quotient bit per step
	localparam int DIV_W = 34;

	// division by 1000 below 2^33: drop three bits, then multiply by the reciprocal of 125
	localparam logic [30:0] MS_RECIP = 31'd1099511628;
	localparam int MS_SHIFT = 37;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned ONE_Q30 = 64'd1073741824;

	typedef enum logic [1:0] {
		KIND_START_END,
		KIND_START_MAG,
		KIND_STOP,
		KIND_UPDATE
	} kind_e;

	typedef enum logic [1:0] {
		PROF_HALF_COS,
		PROF_SINUSOID,
		PROF_RAMP
	} profile_e;

	typedef enum logic [1:0] {
		DIV_MOD,
		DIV_PHASE
	} div_op_e;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_SETUP,
		ST_PLAN,
		ST_DIV_MOD,
		ST_DIV_PHASE,
		ST_ANGLE,
		ST_ROM,
		ST_MULT,
		ST_ABS,
		ST_SCALE,
		ST_DIV_MS,
		ST_FINISH
	} state_e;

	typedef struct packed {
		logic [1:0] kind;
		logic [3:0] joint;
		logic [31:0] now_ms;
		logic signed [31:0] current_pos;
		logic signed [31:0] current_vel;
		logic signed [31:0] target;
		logic [15:0] period_ms;
	} item_t;

	typedef struct packed {
		logic [3:0] joint_echo;
		logic signed [31:0] desired_pos;
		logic signed [31:0] desired_vel;
		logic drive_zero;
		logic active;
	} result_t;

	typedef struct packed {
		logic [31:0] start_time;
		logic signed [31:0] start_pos;
		logic signed [31:0] mag;
		logic [15:0] period;
		logic signed [31:0] last_sp;
		logic signed [31:0] held_vel;
	} rec_t;

	localparam rec_t REC_RESET = '{32'd0, 32'sd0, 32'sd0, 16'd1, 32'sd0, 32'sd0};

	typedef struct packed {
		logic load_item;
		logic read_rec;
		logic setup;
		logic div_start;
		div_op_e div_op;
		logic angle;
		logic mult;
		logic abs_en;
		logic scale;
		logic finish;
	} ctrl_t;

	typedef struct packed {
		logic [1:0] kind;
		logic joint_ok;
		logic lt1;
		logic lt2;
		logic lt4;
		logic div_busy;
	} status_t;

endpackage

/* src/jctg_div.sv */
// restoring divider, one quotient bit per cycle, remainder kept below the divisor
module jctg_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [jctg_pkg::DIV_W-1:0] num,
	input  logic [15:0]                rem_init,
	input  logic [15:0]                dsr,
	output logic                       busy,
	output logic [jctg_pkg::DIV_W-1:0] quo,
	output logic [15:0]                rem
);
	import jctg_pkg::*;

	localparam int CW = $clog2(DIV_W + 1);

	logic [DIV_W-1:0] num_q;
	logic [DIV_W-1:0] quo_q;
	logic [15:0] rem_q;
	logic [15:0] dsr_q;
	logic [CW-1:0] cnt_q;
	logic [16:0] trial;
	logic [16:0] diff;
	logic ge;

	assign trial = {rem_q, num_q[DIV_W-1]};
	assign diff = trial - {1'b0, dsr_q};
	assign ge = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(DIV_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			rem_q <= rem_init;
			dsr_q <= dsr;
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			num_q <= {num_q[DIV_W-2:0], 1'b0};
			rem_q <= ge ? diff[15:0] : trial[15:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	assign busy = cnt_q != '0;
	assign quo = quo_q;
	assign rem = rem_q;

endmodule

/* src/jctg_sine_rom.sv */
// quarter-wave sine table, registered read, gives the q16 value with a full-scale peak
module jctg_sine_rom #(
	parameter int DEPTH = jctg_pkg::SINE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic [$clog2(DEPTH + 1)-1:0]   addr,
	output logic [16:0]                    value
);
	import jctg_pkg::*;

	localparam int AW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);

	// taylor series sine in q30, scaled to 16 bits
	function automatic logic [DEPTH-1:0][15:0] build_rom();
		logic [DEPTH-1:0][15:0] r;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		longint unsigned s;
		int i;
		r = '0;
		for (i = 0; i < DEPTH; i++) begin
			x = HALF_PI_Q30 * longint'(i) / DEPTH;
			x2 = (x * x) >> 30;
			t = ONE_Q30 - x2 / 110;
			t = ONE_Q30 - ((x2 * t) >> 30) / 72;
			t = ONE_Q30 - ((x2 * t) >> 30) / 42;
			t = ONE_Q30 - ((x2 * t) >> 30) / 20;
			t = ONE_Q30 - ((x2 * t) >> 30) / 6;
			s = (x * t) >> 30;
			s = (s * 64'd65535 + (64'd1 << 29)) >> 30;
			if (s > 64'd65535) s = 64'd65535;
			r[i] = s[15:0];
		end
		return r;
	endfunction

	localparam logic [DEPTH-1:0][15:0] ROM = build_rom();

	logic full;
	logic [IW-1:0] rd_idx;
	logic [15:0] raw;
	logic [16:0] val_q;

	assign full = addr >= AW'(DEPTH);
	assign rd_idx = full ? '0 : IW'(addr);
	assign raw = ROM[rd_idx];

	always_ff @(posedge clk) begin
		val_q <= full ? 17'd65536 : {1'b0, raw} + 17'(raw[15]);
	end

	assign value = val_q;

endmodule

/* src/jctg_ctrl.sv */
// controller state machine: sequences record access, divisions and the profile stages
module jctg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [1:0]        mode,
	input  jctg_pkg::status_t status,
	output jctg_pkg::ctrl_t   ctrl,
	output logic              busy
);
	import jctg_pkg::*;

	state_e state_q;
	state_e state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctrl = '0;
		ctrl.div_op = DIV_MOD;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					ctrl.load_item = 1'b1;
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				ctrl.read_rec = 1'b1;
				if (!status.joint_ok) begin
					state_d = ST_IDLE;
				end else if (status.kind == KIND_UPDATE) begin
					state_d = ST_SETUP;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_SETUP: begin
				ctrl.setup = 1'b1;
				state_d = ST_PLAN;
			end
			ST_PLAN: begin
				priority if ((mode != PROF_HALF_COS && mode != PROF_SINUSOID && mode != PROF_RAMP)
						|| (mode == PROF_HALF_COS && !status.lt1)) begin
					state_d = ST_FINISH;
				end else if (mode == PROF_RAMP && !status.lt2) begin
					state_d = ST_ABS;
				end else if (mode == PROF_SINUSOID && !status.lt4) begin
					ctrl.div_start = 1'b1;
					ctrl.div_op = DIV_MOD;
					state_d = ST_DIV_MOD;
				end else begin
					ctrl.div_start = 1'b1;
					ctrl.div_op = DIV_PHASE;
					state_d = ST_DIV_PHASE;
				end
			end
			ST_DIV_MOD: begin
				if (!status.div_busy) begin
					ctrl.div_start = 1'b1;
					ctrl.div_op = DIV_PHASE;
					state_d = ST_DIV_PHASE;
				end
			end
			ST_DIV_PHASE: begin
				if (!status.div_busy) state_d = ST_ANGLE;
			end
			ST_ANGLE: begin
				ctrl.angle = 1'b1;
				state_d = ST_ROM;
			end
			ST_ROM: begin
				state_d = ST_MULT;
			end
			ST_MULT: begin
				ctrl.mult = 1'b1;
				state_d = ST_ABS;
			end
			ST_ABS: begin
				ctrl.abs_en = 1'b1;
				state_d = ST_SCALE;
			end
			ST_SCALE: begin
				ctrl.scale = 1'b1;
				if (mode == PROF_RAMP) begin
					state_d = ST_DIV_MS;
				end else begin
					state_d = ST_FINISH;
				end
			end
			// wait state while the reciprocal multiply result is registered
			ST_DIV_MS: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				ctrl.finish = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = state_q != ST_IDLE;

endmodule

/* src/jctg_dp.sv */
// datapath: trajectory records, elapsed time, phase, table lookup, scaling and result register
module jctg_dp #(
	parameter int NUM_JOINTS = jctg_pkg::NUM_JOINTS_DEF,
	parameter int SINE_TABLE_DEPTH = jctg_pkg::SINE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  jctg_pkg::item_t   item,
	input  logic [1:0]        mode,
	input  jctg_pkg::ctrl_t   ctrl,
	output jctg_pkg::status_t status,
	output logic              done,
	output jctg_pkg::result_t result
);
	import jctg_pkg::*;

	localparam int JW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
	localparam int AW = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int MW = 30 + AW;
	localparam int PW = 51;

	function automatic logic signed [31:0] sat36(input logic signed [35:0] v);
		if (v > 36'sd2147483647) return 32'sh7fff_ffff;
		if (v < -36'sd2147483648) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	item_t item_q;
	rec_t mem [NUM_JOINTS];
	logic [NUM_JOINTS-1:0] valid_q;
	rec_t rec_q;
	rec_t new_rec;
	logic [JW-1:0] idx;
	logic joint_ok;

	logic [31:0] t_d;
	logic [15:0] p_d;
	logic [31:0] t_q;
	logic [15:0] p_q;
	logic lt1_q, lt2_q, lt4_q;
	logic use_sin;
	logic is_cos_half;

	logic [DIV_W-1:0] div_num;
	logic [15:0] div_rem_init;
	logic [15:0] div_dsr;
	logic div_busy;
	logic [DIV_W-1:0] div_quo;
	logic [15:0] div_rem;

	logic [31:0] ph_base;
	logic [31:0] ph;
	logic [MW-1:0] idx_prod;
	logic [AW-1:0] tidx_q;
	logic [1:0] quad_q;
	logic [AW-1:0] rom_addr;
	logic [16:0] sin_v;
	logic signed [17:0] c_d;
	logic signed [18:0] factor_d;
	logic signed [PW-1:0] prod_q;
	logic signed [PW-1:0] abs_src;
	logic [PW-1:0] abs_q;
	logic neg_q;
	logic [PW-1:0] rnd_sum;
	logic [DIV_W-1:0] scaled_d;
	logic [DIV_W-1:0] scaled_q;

	logic [29:0] ms_num;
	logic [60:0] ms_prod;
	logic [DIV_W-1:0] ms_quo_q;

	logic [DIV_W-1:0] q_mag;
	logic signed [35:0] sq;
	logic signed [35:0] base;
	logic signed [35:0] sum36;
	logic hold;
	logic drive_d;
	logic active_d;

	result_t result_q;
	logic done_q;

	assign idx = JW'(item_q.joint);
	assign joint_ok = 32'(item_q.joint) < NUM_JOINTS;

	always_ff @(posedge clk) begin
		if (ctrl.load_item) item_q <= item;
	end

	// record store: read before modify, written back when the result leaves
	always_ff @(posedge clk) begin
		if (ctrl.read_rec) rec_q <= valid_q[idx] ? mem[idx] : REC_RESET;
		if (ctrl.finish) mem[idx] <= new_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctrl.finish) begin
			valid_q[idx] <= 1'b1;
		end
	end

	// elapsed time wraps modulo 2^32
	assign t_d = item_q.now_ms - rec_q.start_time;
	assign p_d = (rec_q.period == 16'd0) ? 16'd1 : rec_q.period;

	always_ff @(posedge clk) begin
		if (ctrl.setup) begin
			t_q <= t_d;
			p_q <= p_d;
			lt1_q <= t_d < {16'd0, p_d};
			lt2_q <= {t_d, 1'b0} < {17'd0, p_d};
			lt4_q <= {t_d, 2'b00} < {18'd0, p_d};
		end
	end

	assign use_sin = (mode == PROF_SINUSOID) && !lt4_q;
	assign is_cos_half = (mode == PROF_HALF_COS) || ((mode == PROF_SINUSOID) && lt4_q);

	always_comb begin
		unique case (ctrl.div_op)
			DIV_MOD: begin
				div_num = {2'b00, t_q};
				div_rem_init = 16'd0;
				div_dsr = p_q;
			end
			DIV_PHASE: begin
				div_num = '0;
				// fraction numerator is below the period in every case
				if (use_sin) begin
					div_rem_init = div_rem;
				end else if (mode == PROF_SINUSOID) begin
					div_rem_init = {t_q[13:0], 2'b00};
				end else begin
					div_rem_init = t_q[15:0];
				end
				div_dsr = p_q;
			end
			default: begin
				div_num = '0;
				div_rem_init = 16'd0;
				div_dsr = p_q;
			end
		endcase
	end

	jctg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctrl.div_start),
		.num      (div_num),
		.rem_init (div_rem_init),
		.dsr      (div_dsr),
		.busy     (div_busy),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	// quotient carries two or three extra fraction bits
	assign ph_base = is_cos_half ? {1'b0, div_quo[DIV_W-1:3]} : div_quo[DIV_W-1:2];
	assign ph = use_sin ? ph_base : ph_base + 32'h4000_0000;
	assign idx_prod = MW'(ph[29:0]) * MW'(SINE_TABLE_DEPTH);

	always_ff @(posedge clk) begin
		if (ctrl.angle) begin
			tidx_q <= idx_prod[MW-1:30];
			quad_q <= ph[31:30];
		end
	end

	assign rom_addr = quad_q[0] ? AW'(SINE_TABLE_DEPTH) - tidx_q : tidx_q;

	jctg_sine_rom #(
		.DEPTH (SINE_TABLE_DEPTH)
	) u_rom (
		.clk   (clk),
		.addr  (rom_addr),
		.value (sin_v)
	);

	assign c_d = quad_q[1] ? -$signed({1'b0, sin_v}) : $signed({1'b0, sin_v});
	assign factor_d = use_sin ? 19'(c_d) : 19'sd65536 - 19'(c_d);

	always_ff @(posedge clk) begin
		if (ctrl.mult) prod_q <= PW'($signed(rec_q.mag)) * PW'(factor_d);
	end

	assign abs_src = ((mode == PROF_RAMP) && !lt2_q) ? PW'($signed(rec_q.mag)) : prod_q;

	always_ff @(posedge clk) begin
		if (ctrl.abs_en) begin
			neg_q <= abs_src[PW-1];
			abs_q <= abs_src[PW-1] ? PW'(-abs_src) : abs_src;
		end
	end

	// round half away from zero on the magnitude
	always_comb begin
		if (use_sin) begin
			rnd_sum = abs_q + PW'(32768);
			scaled_d = DIV_W'(rnd_sum >> 16);
		end else if (mode == PROF_RAMP) begin
			if (lt2_q) begin
				rnd_sum = abs_q + PW'(32768000);
				scaled_d = DIV_W'(rnd_sum >> 16);
			end else begin
				rnd_sum = abs_q + PW'(500);
				scaled_d = DIV_W'(rnd_sum);
			end
		end else begin
			rnd_sum = abs_q + PW'(65536);
			scaled_d = DIV_W'(rnd_sum >> 17);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.scale) scaled_q <= scaled_d;
	end

	// ramp step divided by 1000, exact while the scaled value stays below 2^33
	assign ms_num = scaled_q[32:3];
	assign ms_prod = 61'(ms_num) * 61'(MS_RECIP);

	always_ff @(posedge clk) begin
		ms_quo_q <= DIV_W'(ms_prod[60:MS_SHIFT]);
	end

	assign q_mag = (mode == PROF_RAMP) ? ms_quo_q : scaled_q;
	assign sq = neg_q ? -$signed({2'b00, q_mag}) : $signed({2'b00, q_mag});
	assign base = (mode == PROF_RAMP) ? 36'($signed(rec_q.last_sp)) : 36'($signed(rec_q.start_pos));
	assign sum36 = (mode == PROF_SINUSOID) ? base - sq : base + sq;
	assign hold = !(((mode == PROF_HALF_COS) && lt1_q) || (mode == PROF_SINUSOID)
		|| (mode == PROF_RAMP));

	always_comb begin
		new_rec = rec_q;
		drive_d = 1'b0;
		active_d = 1'b0;
		unique case (item_q.kind)
			KIND_START_END, KIND_START_MAG: begin
				new_rec.start_time = item_q.now_ms;
				new_rec.start_pos = item_q.current_pos;
				new_rec.last_sp = item_q.current_pos;
				new_rec.held_vel = item_q.current_vel;
				new_rec.mag = (item_q.kind == KIND_START_END)
					? sat36(36'($signed(item_q.target)) - 36'($signed(item_q.current_pos)))
					: item_q.target;
				new_rec.period = (item_q.period_ms == 16'd0) ? 16'd1 : item_q.period_ms;
			end
			KIND_STOP: begin
				new_rec.start_time = item_q.now_ms;
				new_rec.start_pos = item_q.current_pos;
				new_rec.last_sp = item_q.current_pos;
				new_rec.held_vel = 32'sd0;
				drive_d = 1'b1;
			end
			KIND_UPDATE: begin
				if (!hold) new_rec.last_sp = sat36(sum36);
				active_d = (mode == PROF_HALF_COS) && lt1_q;
			end
			default: begin
				new_rec = rec_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.finish) begin
			result_q.joint_echo <= item_q.joint;
			result_q.desired_pos <= new_rec.last_sp;
			result_q.desired_vel <= new_rec.held_vel;
			result_q.drive_zero <= drive_d;
			result_q.active <= active_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctrl.finish;
		end
	end

	assign status.kind = item_q.kind;
	assign status.joint_ok = joint_ok;
	assign status.lt1 = lt1_q;
	assign status.lt2 = lt2_q;
	assign status.lt4 = lt4_q;
	assign status.div_busy = div_busy;

	assign done = done_q;
	assign result = result_q;

endmodule

/* src/joint_cosine_trajectory_generator_unit.sv */
// top level: profile register, controller and datapath of the joint trajectory generator
// start and stop items: result strobe after the record read and the write-back, no divider run
// updates: the 34-step divider runs once, twice for the sinusoid after its first quarter, then table
// lookup and scaling; past its first half the ramp skips divider and table; held setpoints skip all
// one item at a time: busy stays high from the transfer to the result strobe, none for a bad joint
// reset clears the profile register, the record valid bits and the controller; records read as reset
module joint_cosine_trajectory_generator_unit #(
	parameter int NUM_JOINTS = jctg_pkg::NUM_JOINTS_DEF,
	parameter int SINE_TABLE_DEPTH = jctg_pkg::SINE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  jctg_pkg::item_t   item,
	output logic              done,
	output jctg_pkg::result_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_data
);
	import jctg_pkg::*;

	logic [1:0] mode_q;
	ctrl_t ctrl;
	status_t status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= PROF_HALF_COS;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= cfg_data;
		end
	end

	jctg_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode_q),
		.status (status),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	jctg_dp #(
		.NUM_JOINTS       (NUM_JOINTS),
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.mode   (mode_q),
		.ctrl   (ctrl),
		.status (status),
		.done   (done),
		.result (result)
	);

	// result strobe only lands once the controller is back at rest
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result strobe while busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("result strobe longer than one cycle");

	a_stop_vel: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.drive_zero) |-> (result.desired_vel == 32'sd0 && !result.active))
		else $error("stop result with nonzero velocity or active flag");

endmodule

/* tb/sv/joint_cosine_trajectory_generator_unit_test.sv */
// self-checking testbench of the joint cosine trajectory generator: directed table, then random moves
`timescale 1ns / 100ps

module joint_cosine_trajectory_generator_unit_test;
	import jctg_pkg::*;

	localparam int JOINTS = 16;
	localparam int DEPTH = 1024;
	localparam int IDLE_LIMIT = 4000;
	localparam int PHASE_ITEMS = 90;

	typedef struct {
		item_t it;
		bit has_exp;
		result_t exp;
	} row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	item_t item;
	logic done;
	result_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_data;

	// trajectory records as the block should hold them
	logic [15:0] quarter_sine [DEPTH];
	logic [31:0] traj_t0 [JOINTS];
	logic signed [31:0] traj_origin [JOINTS];
	logic signed [31:0] traj_mag [JOINTS];
	logic [15:0] traj_period [JOINTS];
	logic signed [31:0] traj_setpoint [JOINTS];
	logic signed [31:0] traj_vel [JOINTS];
	logic [1:0] profile;

	result_t pending_setpoints[$];
	row_t directed_rows[$];
	bit failed;
	int idle_cycles;

	joint_cosine_trajectory_generator_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic void build_sine();
		longint unsigned x, x2, t, s;
		for (int i = 0; i < DEPTH; i++) begin
			x = HALF_PI_Q30 * longint'(i) / DEPTH;
			x2 = (x * x) >> 30;
			t = ONE_Q30 - x2 / 110;
			t = ONE_Q30 - ((x2 * t) >> 30) / 72;
			t = ONE_Q30 - ((x2 * t) >> 30) / 42;
			t = ONE_Q30 - ((x2 * t) >> 30) / 20;
			t = ONE_Q30 - ((x2 * t) >> 30) / 6;
			s = (x * t) >> 30;
			s = (s * 65535 + (64'd1 << 29)) >> 30;
			if (s > 65535) s = 65535;
			quarter_sine[i] = s[15:0];
		end
	endfunction

	function automatic longint quarter_q16(longint unsigned i);
		logic [15:0] v;
		if (i >= DEPTH) return 65536;
		v = quarter_sine[i];
		return longint'(v) + longint'(v >> 15);
	endfunction

	function automatic longint sine_q16(logic [31:0] ph);
		longint unsigned idx;
		longint v;
		idx = (longint'(ph[29:0]) * DEPTH) >> 30;
		v = ph[30] ? quarter_q16(DEPTH - idx) : quarter_q16(idx);
		return ph[31] ? -v : v;
	endfunction

	function automatic longint cosine_q16(logic [31:0] ph);
		return sine_q16(ph + 32'h4000_0000);
	endfunction

	// divide, rounding half away from zero
	function automatic longint round_div(longint x, longint unsigned d);
		longint unsigned m, q;
		m = (x < 0) ? longint'(-x) : x;
		q = (m + d / 2) / d;
		return (x < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > 64'sd2147483647) return 32'sh7fff_ffff;
		if (v < -64'sd2147483648) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic result_t trajectory_step(item_t it);
		result_t r;
		int j;
		longint unsigned t, p;
		longint mag, org, c, inc;
		logic [31:0] ph;
		j = int'(it.joint);
		r = '0;
		if (it.kind == KIND_START_END || it.kind == KIND_START_MAG) begin
			traj_t0[j] = it.now_ms;
			traj_origin[j] = it.current_pos;
			traj_setpoint[j] = it.current_pos;
			traj_vel[j] = it.current_vel;
			traj_mag[j] = (it.kind == KIND_START_END)
				? clamp32(longint'(it.target) - longint'(it.current_pos)) : it.target;
			traj_period[j] = (it.period_ms == 0) ? 16'd1 : it.period_ms;
		end else if (it.kind == KIND_STOP) begin
			traj_t0[j] = it.now_ms;
			traj_origin[j] = it.current_pos;
			traj_setpoint[j] = it.current_pos;
			traj_vel[j] = 0;
			r.drive_zero = 1'b1;
		end else begin
			t = 64'(32'(it.now_ms - traj_t0[j]));
			p = 64'(traj_period[j]);
			mag = traj_mag[j];
			org = traj_origin[j];
			case (profile)
				PROF_HALF_COS: begin
					if (t < p) begin
						ph = 32'((t << 31) / p);
						c = cosine_q16(ph);
						traj_setpoint[j] = clamp32(org + round_div(mag * (65536 - c), 131072));
						r.active = 1'b1;
					end
				end
				PROF_SINUSOID: begin
					if (4 * t < p) begin
						ph = 32'((t << 33) / p);
						c = cosine_q16(ph);
						traj_setpoint[j] = clamp32(org - round_div(mag * (65536 - c), 131072));
					end else begin
						ph = 32'(((t % p) << 32) / p);
						c = sine_q16(ph);
						traj_setpoint[j] = clamp32(org - round_div(mag * c, 65536));
					end
				end
				PROF_RAMP: begin
					if (2 * t < p) begin
						ph = 32'((t << 32) / p);
						c = cosine_q16(ph);
						inc = round_div(mag * (65536 - c), 65536000);
					end else begin
						inc = round_div(mag, 1000);
					end
					traj_setpoint[j] = clamp32(longint'(traj_setpoint[j]) + inc);
				end
				default: ;  // unused mode holds the setpoint
			endcase
		end
		r.joint_echo = it.joint;
		r.desired_pos = traj_setpoint[j];
		r.desired_vel = traj_vel[j];
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_item(item_t it, bit has_exp, result_t exp, bit idle);
		int gap;
		result_t r;
		gap = idle ? pick_gap() : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		r = trajectory_step(it);
		pending_setpoints.push_back(has_exp ? exp : r);
	endtask

	task automatic write_profile(logic [1:0] mode);
		start <= 1'b0;
		do @(posedge clk); while (pending_setpoints.size() != 0);
		repeat (8) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= mode;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		profile = mode;
	endtask

	function automatic void add_row(kind_e k, int j, logic [31:0] now, logic [31:0] pos,
			logic [31:0] vel, logic [31:0] tgt, logic [15:0] per, bit has_exp,
			logic [31:0] e_pos, logic [31:0] e_vel, bit e_drive, bit e_act);
		row_t row;
		row.it = '{k, j[3:0], now, pos, vel, tgt, per};
		row.has_exp = has_exp;
		row.exp = '{j[3:0], e_pos, e_vel, e_drive, e_act};
		directed_rows.push_back(row);
	endfunction

	function automatic item_t random_item();
		item_t it;
		int r, j;
		it.joint = 4'($urandom_range(0, JOINTS - 1));
		j = int'(it.joint);
		it.current_pos = $urandom;
		it.current_vel = $urandom;
		r = $urandom_range(0, 99);
		it.target = (r < 50) ? $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000
			: $urandom;
		r = $urandom_range(0, 99);
		it.period_ms = (r < 70) ? 16'($urandom_range(1, 400))
			: (r < 92) ? 16'($urandom_range(1, 65535)) : (r < 96) ? 16'hffff : 16'd0;
		r = $urandom_range(0, 99);
		if (r < 18) begin
			it.kind = ($urandom_range(0, 1) != 0) ? KIND_START_MAG : KIND_START_END;
			it.now_ms = $urandom;
		end else if (r < 26) begin
			it.kind = KIND_STOP;
			it.now_ms = $urandom;
		end else begin
			// updates mostly land within a few periods of the move's start
			it.kind = KIND_UPDATE;
			it.now_ms = ($urandom_range(0, 9) == 0) ? $urandom
				: traj_t0[j] + $urandom_range(0, 3 * int'(traj_period[j]));
		end
		return it;
	endfunction

	// results come for one cycle and cannot be held off
	always @(posedge clk) begin
		result_t e;
		if (arst_n && done) begin
			if (pending_setpoints.size() == 0) begin
				$error("result with nothing expected: joint_echo %0d", result.joint_echo);
				failed = 1'b1;
			end else begin
				e = pending_setpoints.pop_front();
				if (result.joint_echo !== e.joint_echo) begin
					$error("joint_echo expected %0d actual %0d", e.joint_echo, result.joint_echo);
					failed = 1'b1;
				end
				if (result.desired_pos !== e.desired_pos) begin
					$error("desired_pos expected %0d actual %0d", e.desired_pos,
						result.desired_pos);
					failed = 1'b1;
				end
				if (result.desired_vel !== e.desired_vel) begin
					$error("desired_vel expected %0d actual %0d", e.desired_vel,
						result.desired_vel);
					failed = 1'b1;
				end
				if (result.drive_zero !== e.drive_zero) begin
					$error("drive_zero expected %0b actual %0b", e.drive_zero, result.drive_zero);
					failed = 1'b1;
				end
				if (result.active !== e.active) begin
					$error("active expected %0b actual %0b", e.active, result.active);
					failed = 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("joint_cosine_trajectory_generator_unit test failed");
			$finish;
		end
	end

	initial begin
		logic [1:0] phase_modes [6];
		item_t it;
		result_t none;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		failed = 1'b0;
		idle_cycles = 0;
		none = '0;
		profile = PROF_HALF_COS;
		build_sine();
		for (int j = 0; j < JOINTS; j++) begin
			traj_t0[j] = 0;
			traj_origin[j] = 0;
			traj_mag[j] = 0;
			traj_period[j] = 1;
			traj_setpoint[j] = 0;
			traj_vel[j] = 0;
		end

		// half-cosine profile, first on records straight out of reset
		add_row(KIND_UPDATE, 0, 32'd0, 32'h1234_5678, 32'h0, 32'h0, 16'd5, 1, 0, 0, 0, 1);
		add_row(KIND_UPDATE, 4, 32'd7, 32'h0, 32'h0, 32'h0, 16'd5, 1, 0, 0, 0, 0);
		add_row(KIND_START_END, 1, 32'd1000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
			16'd100, 1, 32'h8000_0000, 32'h7fff_ffff, 0, 0);
		add_row(KIND_UPDATE, 1, 32'd1050, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(KIND_UPDATE, 1, 32'd1099, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(KIND_UPDATE, 1, 32'd1100, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(KIND_START_MAG, 2, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
			16'd0, 1, 32'h7fff_ffff, 32'h8000_0000, 0, 0);
		add_row(KIND_UPDATE, 2, 32'hffff_ffff, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(KIND_UPDATE, 2, 32'd4, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(KIND_STOP, 3, 32'd77, 32'h7fff_ffff, 32'h1111_1111, 32'hffff_ffff, 16'hffff,
			1, 32'h7fff_ffff, 0, 1, 0);
		add_row(KIND_UPDATE, 3, 32'd77, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(KIND_START_END, 15, 32'hffff_fff0, 32'h7fff_ffff, 32'hffff_ffff, 32'h8000_0000,
			16'hffff, 1, 32'h7fff_ffff, 32'hffff_ffff, 0, 0);
		add_row(KIND_UPDATE, 15, 32'h0000_0100, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(KIND_UPDATE, 15, 32'h0000_8000, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(KIND_START_MAG, 9, 32'd0, 32'h0, 32'h0, 32'h0001_0000, 16'd1, 1, 0, 0, 0, 0);
		add_row(KIND_UPDATE, 9, 32'd0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(KIND_STOP, 9, 32'd3, 32'h8000_0000, 32'h0, 32'h0, 16'd0,
			1, 32'h8000_0000, 0, 1, 0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_item(directed_rows[i].it, directed_rows[i].has_exp, directed_rows[i].exp, 1);

		phase_modes = '{PROF_SINUSOID, PROF_RAMP, 2'd3, PROF_HALF_COS, PROF_RAMP, PROF_SINUSOID};
		foreach (phase_modes[p]) begin
			write_profile(phase_modes[p]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				it = random_item();
				// one phase runs back to back
				send_item(it, 0, none, p != 3);
			end
		end

		start <= 1'b0;
		while (pending_setpoints.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (!failed)
			$display("joint_cosine_trajectory_generator_unit test passed");
		else
			$display("joint_cosine_trajectory_generator_unit test failed");
		$finish;
	end

endmodule
